[rtl/hgi_pkg.sv]
// ----------------------------------------------------------------------------
// hgi_pkg
// Shared types, codes and arithmetic helpers for the height grid interpolator.
// ----------------------------------------------------------------------------
package hgi_pkg;

  localparam int GRID_COLS_DEF = 256;
  localparam int GRID_ROWS_DEF = 256;
  localparam int PAW           = 5;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] METH_TRI    = 2'd0;
  localparam logic [1:0] METH_BILIN  = 2'd1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_CLAMP  = 2'd1;
  localparam logic [1:0] STAT_METHOD = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_SCALE_X   = 3'd2;
  localparam logic [2:0] REG_SCALE_Y   = 3'd3;
  localparam logic [2:0] REG_COLS_USED = 3'd4;
  localparam logic [2:0] REG_ROWS_USED = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic        [31:0] scale_x;
    logic        [31:0] scale_y;
    logic        [8:0]  cols_used;
    logic        [8:0]  rows_used;
  } cfg_t;

  // Q20.32 sum to Q16.16, half up, saturated
  function automatic logic signed [31:0] round_q16(input logic signed [51:0] s);
    logic signed [51:0] t;
    logic signed [35:0] q;
    t = s + 52'sd32768;
    q = 36'(t >>> 16);
    if (q > 36'sd2147483647) return 32'sh7fffffff;
    if (q < -36'sd2147483648) return 32'sh80000000;
    return 32'(q);
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) return 32'sh7fffffff;
    if (s < -33'sd2147483648) return 32'sh80000000;
    return 32'(s);
  endfunction

endpackage

[rtl/hgi_if.sv]
// ----------------------------------------------------------------------------
// hgi_if
// Request and response channels of the height grid interpolator.
// ----------------------------------------------------------------------------
interface hgi_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [7:0]  col;
  logic        [7:0]  row;
  logic signed [31:0] sample;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic        [1:0]  method;

  modport source (output valid, kind, col, row, sample, query_x, query_y, method,
                  input ready);
  modport sink   (input valid, kind, col, row, sample, query_x, query_y, method,
                  output ready);
endinterface

interface hgi_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height;
  logic        [1:0]  status;

  modport source (output valid, height, status, input ready);
  modport sink   (input valid, height, status, output ready);
endinterface

[rtl/hgi_ram.sv]
// ----------------------------------------------------------------------------
// hgi_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module hgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/hgi_axis.sv]
// ----------------------------------------------------------------------------
// hgi_axis
// World to grid mapping for one axis: registered scale product, then clamp
// and split into cell index and fraction.
// ----------------------------------------------------------------------------
module hgi_axis #(
  parameter int N = 256,
  localparam int CW = $clog2(N)
) (
  input  logic               clk,
  input  logic signed [31:0] w,
  input  logic signed [31:0] org,
  input  logic        [31:0] scl,
  input  logic [CW-1:0]      nmax,
  output logic [CW-1:0]      cidx,
  output logic [16:0]        frac,
  output logic               clamp
);

  logic signed [32:0] d;
  logic               d_pos;
  logic               d_neg;
  logic               szero;
  logic [63:0]        prod;
  logic [47:0]        g;
  logic [47:0]        lim;
  logic [47:0]        gc;
  logic [CW-1:0]      c;

  assign d = 33'(w) - 33'(org);

  always_ff @(posedge clk) begin
    d_pos <= !d[32] && (d != 33'sd0);
    d_neg <= d[32];
    szero <= (scl == 32'd0);
    prod  <= 64'(d[31:0]) * 64'(scl);
  end

  always_comb begin
    g   = prod[63:16];
    lim = 48'(nmax) << 16;
    if (!d_pos) begin
      gc    = '0;
      clamp = d_neg && !szero;
    end else if (g > lim) begin
      gc    = lim;
      clamp = 1'b1;
    end else begin
      gc    = g;
      clamp = 1'b0;
    end
    c = gc[16 +: CW];
    if (c >= nmax) begin
      cidx = nmax - 1'b1;
      frac = hgi_pkg::ONE_Q16;
    end else begin
      cidx = c;
      frac = {1'b0, gc[15:0]};
    end
  end

endmodule

[rtl/hgi_regs.sv]
// ----------------------------------------------------------------------------
// hgi_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module hgi_regs
  import hgi_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output cfg_t           cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x  <= '0;
      cfg.origin_y  <= '0;
      cfg.scale_x   <= 32'h0001_0000;
      cfg.scale_y   <= 32'h0001_0000;
      cfg.cols_used <= 9'd256;
      cfg.rows_used <= 9'd256;
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X:  cfg.origin_x  <= pwdata;
        REG_ORIGIN_Y:  cfg.origin_y  <= pwdata;
        REG_SCALE_X:   cfg.scale_x   <= pwdata;
        REG_SCALE_Y:   cfg.scale_y   <= pwdata;
        REG_COLS_USED: cfg.cols_used <= pwdata[8:0];
        REG_ROWS_USED: cfg.rows_used <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:  prdata = cfg.origin_x;
      REG_ORIGIN_Y:  prdata = cfg.origin_y;
      REG_SCALE_X:   prdata = cfg.scale_x;
      REG_SCALE_Y:   prdata = cfg.scale_y;
      REG_COLS_USED: prdata = 32'(cfg.cols_used);
      REG_ROWS_USED: prdata = 32'(cfg.rows_used);
      default:       prdata = '0;
    endcase
  end

endmodule

[rtl/hgi_core.sv]
// ----------------------------------------------------------------------------
// hgi_core
// Sequencer around the height memory: clear pass, cell write and add,
// four-read query and a shared multiply-accumulate for the blend.
// ----------------------------------------------------------------------------
module hgi_core
  import hgi_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  hgi_req_if.sink    rq,
  hgi_rsp_if.source  rs
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(GRID_COLS);
  localparam int CYW   = $clog2(GRID_ROWS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WR, S_ARD, S_AWR, S_MUL, S_SPLIT,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_CALC, S_DONE
  } state_t;

  state_t state;

  logic [AW-1:0]      clr_cnt;
  logic [7:0]         col_r;
  logic [7:0]         row_r;
  logic signed [31:0] sample_r;
  logic signed [31:0] qx_r;
  logic signed [31:0] qy_r;
  logic               bil;
  logic [CXW-1:0]     cx_r;
  logic [CYW-1:0]     cy_r;
  logic [16:0]        fx_r;
  logic [16:0]        fy_r;
  logic               clamp_r;
  logic signed [31:0] h00, h10, h01, h11, lo, hi;
  logic signed [49:0] prod;
  logic signed [51:0] acc;
  logic [3:0]         k;
  logic signed [31:0] res;
  logic [1:0]         res_st;
  logic               rs_valid;
  logic signed [31:0] rs_height;
  logic [1:0]         rs_status;

  logic [15:0]        ncols, nrows, cu, ru;
  logic [CXW-1:0]     nmax_x;
  logic [CYW-1:0]     nmax_y;
  logic [CXW-1:0]     ax_cell;
  logic [CYW-1:0]     ay_cell;
  logic [16:0]        ax_frac, ay_frac;
  logic               ax_clamp, ay_clamp;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;
  logic [AW-1:0]      waddr;
  logic [CXW-1:0]     rx;
  logic [CYW-1:0]     ry;
  logic               in_range;

  logic [17:0]        fxy;
  logic               tri_lo;
  logic [16:0]        mul_w;
  logic signed [31:0] mul_h;
  logic               acc_ld, acc_add, lo_en, hi_en, fin;
  logic signed [31:0] rnd;

  // effective grid extent
  always_comb begin
    cu = 16'(cfg.cols_used);
    ru = 16'(cfg.rows_used);
    if (cu < 16'd2) ncols = 16'd2;
    else if (cu > 16'(GRID_COLS)) ncols = 16'(GRID_COLS);
    else ncols = cu;
    if (ru < 16'd2) nrows = 16'd2;
    else if (ru > 16'(GRID_ROWS)) nrows = 16'(GRID_ROWS);
    else nrows = ru;
    nmax_x = CXW'(ncols - 16'd1);
    nmax_y = CYW'(nrows - 16'd1);
  end

  assign in_range = (16'(rq.col) < ncols) && (16'(rq.row) < nrows);

  hgi_axis #(.N(GRID_COLS)) u_axis_x (
    .clk(clk), .w(qx_r), .org(cfg.origin_x), .scl(cfg.scale_x), .nmax(nmax_x),
    .cidx(ax_cell), .frac(ax_frac), .clamp(ax_clamp)
  );

  hgi_axis #(.N(GRID_ROWS)) u_axis_y (
    .clk(clk), .w(qy_r), .org(cfg.origin_y), .scl(cfg.scale_y), .nmax(nmax_y),
    .cidx(ay_cell), .frac(ay_frac), .clamp(ay_clamp)
  );

  hgi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  assign waddr = AW'(row_r) * AW'(GRID_COLS) + AW'(col_r);

  // memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = sample_r;
    rx        = cx_r;
    ry        = cy_r;
    case (state)
      S_RD1:   rx = cx_r + 1'b1;
      S_RD2:   ry = cy_r + 1'b1;
      S_RD3: begin
        rx = cx_r + 1'b1;
        ry = cy_r + 1'b1;
      end
      default: ;
    endcase
    mem_addr = AW'(ry) * AW'(GRID_COLS) + AW'(rx);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      S_WR: begin
        mem_we   = 1'b1;
        mem_addr = waddr;
      end
      S_ARD:   mem_addr = waddr;
      S_AWR: begin
        mem_we    = 1'b1;
        mem_addr  = waddr;
        mem_wdata = sat_add32(mem_rdata, sample_r);
      end
      default: ;
    endcase
  end

  // blend schedule
  assign fxy    = 18'(fx_r) + 18'(fy_r);
  assign tri_lo = fxy < 18'(ONE_Q16);
  assign rnd    = round_q16(acc);

  always_comb begin
    mul_w   = '0;
    mul_h   = '0;
    acc_ld  = 1'b0;
    acc_add = 1'b0;
    lo_en   = 1'b0;
    hi_en   = 1'b0;
    fin     = 1'b0;
    if (!bil) begin
      case (k)
        4'd0: begin
          mul_w = tri_lo ? 17'(18'(ONE_Q16) - fxy) : 17'(fxy - 18'(ONE_Q16));
          mul_h = tri_lo ? h00 : h11;
        end
        4'd1: begin
          mul_w  = tri_lo ? fx_r : ONE_Q16 - fx_r;
          mul_h  = tri_lo ? h10 : h01;
          acc_ld = 1'b1;
        end
        4'd2: begin
          mul_w   = tri_lo ? fy_r : ONE_Q16 - fy_r;
          mul_h   = tri_lo ? h01 : h10;
          acc_add = 1'b1;
        end
        4'd3:    acc_add = 1'b1;
        4'd4:    fin = 1'b1;
        default: ;
      endcase
    end else begin
      case (k)
        4'd0: begin
          mul_w = ONE_Q16 - fx_r;
          mul_h = h00;
        end
        4'd1: begin
          mul_w  = fx_r;
          mul_h  = h10;
          acc_ld = 1'b1;
        end
        4'd2: begin
          mul_w   = ONE_Q16 - fx_r;
          mul_h   = h01;
          acc_add = 1'b1;
        end
        4'd3: begin
          mul_w  = fx_r;
          mul_h  = h11;
          acc_ld = 1'b1;
          lo_en  = 1'b1;
        end
        4'd4:    acc_add = 1'b1;
        4'd5:    hi_en = 1'b1;
        4'd6: begin
          mul_w = ONE_Q16 - fy_r;
          mul_h = lo;
        end
        4'd7: begin
          mul_w  = fy_r;
          mul_h  = hi;
          acc_ld = 1'b1;
        end
        4'd8:    acc_add = 1'b1;
        4'd9:    fin = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      rs_valid <= 1'b0;
      k        <= '0;
    end else begin
      prod <= $signed({1'b0, mul_w}) * mul_h;
      if (acc_ld)  acc <= 52'(prod);
      if (acc_add) acc <= acc + 52'(prod);
      if (lo_en)   lo  <= rnd;
      if (hi_en)   hi  <= rnd;
      if (rs_valid && rs.ready && state != S_DONE) rs_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (rq.valid) begin
            col_r    <= rq.col;
            row_r    <= rq.row;
            sample_r <= rq.sample;
            qx_r     <= rq.query_x;
            qy_r     <= rq.query_y;
            bil      <= (rq.method == METH_BILIN);
            case (rq.kind)
              KIND_WRITE: if (in_range) state <= S_WR;
              KIND_ADD:   if (in_range) state <= S_ARD;
              KIND_QUERY: begin
                if (rq.method != METH_TRI && rq.method != METH_BILIN) begin
                  res    <= '0;
                  res_st <= STAT_METHOD;
                  state  <= S_DONE;
                end else begin
                  state <= S_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_WR:    state <= S_IDLE;
        S_ARD:   state <= S_AWR;
        S_AWR:   state <= S_IDLE;
        S_MUL:   state <= S_SPLIT;
        S_SPLIT: begin
          cx_r    <= ax_cell;
          cy_r    <= ay_cell;
          fx_r    <= ax_frac;
          fy_r    <= ay_frac;
          clamp_r <= ax_clamp || ay_clamp;
          state   <= S_RD0;
        end
        S_RD0:   state <= S_RD1;
        S_RD1: begin
          h00   <= mem_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          h10   <= mem_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          h01   <= mem_rdata;
          state <= S_RD4;
        end
        S_RD4: begin
          h11   <= mem_rdata;
          k     <= '0;
          state <= S_CALC;
        end
        S_CALC: begin
          k <= k + 1'b1;
          if (fin) begin
            res    <= rnd;
            res_st <= clamp_r ? STAT_CLAMP : STAT_OK;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rs_valid || rs.ready) begin
            rs_valid  <= 1'b1;
            rs_height <= res;
            rs_status <= res_st;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rq.ready  = (state == S_IDLE);
  assign rs.valid  = rs_valid;
  assign rs.height = rs_height;
  assign rs.status = rs_status;

  a_method_zero: assert property (@(posedge clk) disable iff (rst)
    (rs_valid && rs_status == STAT_METHOD) |-> (rs_height == 32'sd0))
    else $error("method error result carries a height");

  a_cell_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD0) |-> (cx_r < nmax_x && cy_r < nmax_y))
    else $error("query cell beyond grid");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rs_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside completion");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !rs_valid)
    else $error("result pending during clear pass");

endmodule

[rtl/height_grid_interpolator.sv]
// ----------------------------------------------------------------------------
// height_grid_interpolator
// Grid of Q16.16 heights with cell write/add and triangular or bilinear
// interpolated queries.
//
//   channel  dir  carries
//   -------  ---  ---------------------------------------------------
//   req      in   kind, col, row, sample, query_x, query_y, method
//   rsp      out  height, status (one per query)
//   apb      in   origin_x/y, scale_x/y, cols_used, rows_used
//
// An add reads the cell and writes the saturated sum back; a query makes
// four reads of the single-port height RAM and blends them on the shared
// multiply-accumulate. After reset a clear pass zeroes all
// GRID_COLS*GRID_ROWS RAM words with req not ready.
// A stalled rsp item holds the next query in its final state.
// ----------------------------------------------------------------------------
module height_grid_interpolator
  import hgi_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  hgi_req_if.sink        req,
  hgi_rsp_if.source      rsp
);

  cfg_t cfg;

  hgi_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  hgi_core #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .rq(req), .rs(rsp)
  );

endmodule
